// ===== sv/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned OpW   = 4;
  localparam int unsigned ArgW  = 32;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned ValW  = 32;
  localparam int unsigned StW   = 4;
  localparam int unsigned VolW  = 8;
  localparam int unsigned HndW  = 32;
  localparam int unsigned AttW  = 4;
  localparam int unsigned PerW  = 16;
  localparam int unsigned LimW  = 4;
  localparam int unsigned MaxCmds = 3;
  localparam int unsigned CntW  = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  localparam logic [PerW-1:0] PeriodReset = 16'd1000;
  localparam logic [LimW-1:0] LimitReset  = 4'd4;
  localparam logic [VolW-1:0] VolumeReset = 8'd50;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam logic [OpW-1:0] OP_STATUS    = 4'd0;
  localparam logic [OpW-1:0] OP_LINK_UP   = 4'd1;
  localparam logic [OpW-1:0] OP_GOT_IP    = 4'd2;
  localparam logic [OpW-1:0] OP_LINK_DOWN = 4'd3;
  localparam logic [OpW-1:0] OP_START     = 4'd4;
  localparam logic [OpW-1:0] OP_VOLUME    = 4'd5;
  localparam logic [OpW-1:0] OP_STOP      = 4'd6;
  localparam logic [OpW-1:0] OP_STREAM_OK = 4'd7;
  localparam logic [OpW-1:0] OP_STREAM_NG = 4'd8;
  localparam logic [OpW-1:0] OP_DEC_OK    = 4'd9;
  localparam logic [OpW-1:0] OP_DEC_NG    = 4'd10;
  localparam logic [OpW-1:0] OP_PLAY_OK   = 4'd11;
  localparam logic [OpW-1:0] OP_RESTART   = 4'd12;

  localparam logic [CmdW-1:0] CMD_STREAM_START = 4'd0;
  localparam logic [CmdW-1:0] CMD_STREAM_STOP  = 4'd1;
  localparam logic [CmdW-1:0] CMD_DEC_START    = 4'd2;
  localparam logic [CmdW-1:0] CMD_DEC_STOP     = 4'd3;
  localparam logic [CmdW-1:0] CMD_VOLUME       = 4'd4;
  localparam logic [CmdW-1:0] CMD_PLAY_START   = 4'd5;
  localparam logic [CmdW-1:0] CMD_PLAY_STOP    = 4'd6;
  localparam logic [CmdW-1:0] CMD_ARM          = 4'd7;
  localparam logic [CmdW-1:0] CMD_TIMER_STOP   = 4'd8;
  localparam logic [CmdW-1:0] CMD_STATUS       = 4'd9;

  // one event's worth of commands; value belongs to the final command only
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxCmds-1:0][CmdW-1:0] cmd;
    logic [ValW-1:0]              value;
    logic [StW-1:0]               rep_state;
    logic [VolW-1:0]              rep_volume;
    logic [HndW-1:0]              rep_stream;
  } bundle_t;

endpackage

// ===== sv/psc_front.sv =====
module psc_front
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OpW-1:0]      op,
  input  logic [ArgW-1:0]     arg,
  input  logic                cfg_we,
  input  logic                cfg_sel,
  input  logic [PerW-1:0]     cfg_wdata,
  input  logic                q_full,
  output logic                push,
  output bundle_t             push_data
);

  typedef enum logic [StW-1:0] {
    ST_LINK    = 4'd0,
    ST_IP      = 4'd1,
    ST_READY   = 4'd2,
    ST_STREAM  = 4'd3,
    ST_DECODER = 4'd4,
    ST_PLAYER  = 4'd5,
    ST_RUNNING = 4'd6,
    ST_RESTART = 4'd7,
    ST_ERROR   = 4'd8
  } state_t;

  state_t          state, state_next;
  logic [VolW-1:0] volume, volume_next;
  logic [HndW-1:0] handle, handle_next;
  logic [AttW-1:0] attempts, attempts_next;
  logic [PerW-1:0] period;
  logic [LimW-1:0] limit;
  logic            retry_ok;
  logic [ValW-1:0] arm_val;
  logic            accept;
  bundle_t         b;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign retry_ok  = attempts < limit;
  assign arm_val   = {{(ValW-PerW){1'b0}}, period} << attempts;
  assign push      = accept && (b.cnt != '0);
  assign push_data = b;

  always_comb begin
    state_next    = state;
    volume_next   = volume;
    handle_next   = handle;
    attempts_next = attempts;
    b             = '0;
    if (op == OP_STATUS) begin
      b.cnt        = 2'd1;
      b.cmd[0]     = CMD_STATUS;
      b.rep_state  = state;
      b.rep_volume = volume;
      b.rep_stream = handle;
    end else begin
      unique case (state)
        ST_LINK: begin
          if (op == OP_LINK_UP) state_next = ST_IP;
        end
        ST_IP: begin
          if (op == OP_GOT_IP) state_next = ST_READY;
          else if (op == OP_LINK_DOWN) state_next = ST_LINK;
        end
        ST_READY: begin
          if (op == OP_START) begin
            handle_next = arg;
            b.cnt       = 2'd1;
            b.cmd[0]    = CMD_STREAM_START;
            b.value     = arg;
            state_next  = ST_STREAM;
          end else if (op == OP_VOLUME) begin
            volume_next = arg[VolW-1:0];
            b.cnt       = 2'd1;
            b.cmd[0]    = CMD_VOLUME;
            b.value     = {{(ValW-VolW){1'b0}}, arg[VolW-1:0]};
          end else if (op == OP_LINK_DOWN) begin
            state_next = ST_LINK;
          end
        end
        ST_STREAM: begin
          if (op == OP_STREAM_OK) begin
            b.cnt      = 2'd1;
            b.cmd[0]   = CMD_DEC_START;
            state_next = ST_DECODER;
          end else if (op == OP_STREAM_NG) begin
            if (retry_ok) begin
              b.cnt         = 2'd1;
              b.cmd[0]      = CMD_ARM;
              b.value       = arm_val;
              attempts_next = attempts + 1'b1;
              state_next    = ST_RESTART;
            end else begin
              state_next = ST_ERROR;
            end
          end
        end
        ST_DECODER: begin
          if (op == OP_DEC_OK) begin
            b.cnt      = 2'd1;
            b.cmd[0]   = CMD_PLAY_START;
            b.value    = {{(ValW-16){1'b0}}, arg[15:0]};
            state_next = ST_PLAYER;
          end else if (op == OP_DEC_NG) begin
            b.cmd[0] = CMD_STREAM_STOP;
            if (retry_ok) begin
              b.cnt         = 2'd2;
              b.cmd[1]      = CMD_ARM;
              b.value       = arm_val;
              attempts_next = attempts + 1'b1;
              state_next    = ST_RESTART;
            end else begin
              b.cnt      = 2'd1;
              state_next = ST_ERROR;
            end
          end
        end
        ST_PLAYER: begin
          if (op == OP_PLAY_OK) begin
            attempts_next = '0;
            state_next    = ST_RUNNING;
          end
        end
        ST_RUNNING: begin
          if (op == OP_LINK_DOWN || op == OP_STOP) begin
            b.cnt      = 2'd3;
            b.cmd[0]   = CMD_PLAY_STOP;
            b.cmd[1]   = CMD_DEC_STOP;
            b.cmd[2]   = CMD_STREAM_STOP;
            state_next = (op == OP_LINK_DOWN) ? ST_LINK : ST_READY;
          end else if (op == OP_STREAM_NG) begin
            b.cmd[0] = CMD_PLAY_STOP;
            b.cmd[1] = CMD_DEC_STOP;
            if (retry_ok) begin
              b.cnt         = 2'd3;
              b.cmd[2]      = CMD_ARM;
              b.value       = arm_val;
              attempts_next = attempts + 1'b1;
              state_next    = ST_RESTART;
            end else begin
              b.cnt      = 2'd2;
              state_next = ST_ERROR;
            end
          end else if (op == OP_VOLUME) begin
            volume_next = arg[VolW-1:0];
            b.cnt       = 2'd1;
            b.cmd[0]    = CMD_VOLUME;
            b.value     = {{(ValW-VolW){1'b0}}, arg[VolW-1:0]};
          end
        end
        ST_RESTART: begin
          if (op == OP_RESTART) begin
            b.cnt      = 2'd1;
            b.cmd[0]   = CMD_STREAM_START;
            b.value    = handle;
            state_next = ST_STREAM;
          end else if (op == OP_LINK_DOWN) begin
            b.cnt      = 2'd1;
            b.cmd[0]   = CMD_TIMER_STOP;
            state_next = ST_LINK;
          end else if (op == OP_STOP) begin
            b.cnt      = 2'd1;
            b.cmd[0]   = CMD_TIMER_STOP;
            state_next = ST_READY;
          end
        end
        ST_ERROR: begin
          if (op == OP_LINK_DOWN) begin
            state_next = ST_LINK;
          end else if (op == OP_STOP) begin
            attempts_next = '0;
            state_next    = ST_READY;
          end else if (op == OP_START) begin
            attempts_next = '0;
            handle_next   = arg;
            b.cnt         = 2'd1;
            b.cmd[0]      = CMD_STREAM_START;
            b.value       = arg;
            state_next    = ST_STREAM;
          end else if (op == OP_VOLUME) begin
            volume_next = arg[VolW-1:0];
            b.cnt       = 2'd1;
            b.cmd[0]    = CMD_VOLUME;
            b.value     = {{(ValW-VolW){1'b0}}, arg[VolW-1:0]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LINK;
      volume   <= VolumeReset;
      handle   <= '0;
      attempts <= '0;
      period   <= PeriodReset;
      limit    <= LimitReset;
    end else begin
      if (accept) begin
        state    <= state_next;
        volume   <= volume_next;
        handle   <= handle_next;
        attempts <= attempts_next;
      end
      if (cfg_we) begin
        if (cfg_sel == CFG_PERIOD) period <= cfg_wdata;
        else limit <= cfg_wdata[LimW-1:0];
      end
    end
  end

endmodule

// ===== sv/psc_queue.sv =====
module psc_queue
  import psc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    empty,
  output bundle_t head
);

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

// ===== sv/psc_back.sv =====
module psc_back
  import psc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  bundle_t               head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OutDataW-1:0]   out_data,
  output logic                  out_last
);

  logic [CntW-1:0] idx;
  logic            load;
  logic            fin;
  logic [CmdW-1:0] cmd_sel;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign fin     = (idx + 2'd1) == head.cnt;
  assign pop     = load && fin;
  assign cmd_sel = head.cmd[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= fin ? '0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {head.rep_stream, head.rep_volume, head.rep_state,
                   fin ? head.value : {ValW{1'b0}}, cmd_sel};
      out_last <= fin;
    end
  end

endmodule

// ===== sv/playback_session_controller.sv =====
// Session controller for network audio playback.
// Slave stream: one word per event; tdata carries the event code and its
// argument. Master stream: one word per command the event causes (zero to
// three), tlast marking the final command of the event.
// Config channel: cfg_index 0 writes the base retry period, 1 the retry
// limit; always ready, to be written only while the block is idle.
// The front end decodes an event in the cycle it is taken and pushes the
// event's command group into a two-entry queue; the back end sends one
// command per cycle from a registered output stage while m_tready is high.
// The first command of an event is held in a queue entry and then in the
// output register. Throughput: one command per cycle while m_tready is high;
// an event with n commands goes out as n words. Events are taken every cycle
// while the queue has room; events with no command never enter the queue.
// A stalled master side holds the output word; the queue then fills and
// s_tready drops. Reset returns the state to awaiting link, volume 50,
// handle 0, retry count 0, period 1000, limit 4, and empties the queue.
module playback_session_controller
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // operation[3:0], argument[35:4], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // command[3:0], command_value[35:4],
                                         // report_state[39:36], report_volume[47:40],
                                         // report_stream[79:48]
  output logic                m_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [PerW-1:0]     cfg_data
);

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;

  assign cfg_ready = 1'b1;

  psc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tdata[OpW-1:0]),
    .arg       (s_tdata[OpW+ArgW-1:OpW]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  psc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  psc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== bench/playback_session_controller_tb.sv =====
module playback_session_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int PhaseItems = 60;
  localparam int HoldCycles = 64;
  localparam int WatchLimit = 1000;

  typedef enum logic [StW-1:0] {
    S_LINK, S_IP, S_READY, S_STREAM, S_DECODER, S_PLAYER, S_RUNNING, S_RESTART, S_ERROR
  } ses_state_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [ValW-1:0] value;
    logic [StW-1:0]  st;
    logic [VolW-1:0] vol;
    logic [HndW-1:0] hnd;
    logic            last;
  } cmd_word_t;

  typedef struct {
    bit              is_reg;
    logic            reg_idx;
    logic [PerW-1:0] reg_val;
    logic [OpW-1:0]  op;
    logic [ArgW-1:0] arg;
    bit              typed;
    cmd_word_t       want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // operation[3:0], argument[35:4], zero pad
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // command[3:0], command_value[35:4],
                                       // report_state[39:36], report_volume[47:40],
                                       // report_stream[79:48]
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [PerW-1:0]     cfg_data = '0;

  // session model
  ses_state_t      ses_state  = S_LINK;
  logic [VolW-1:0] ses_volume = VolumeReset;
  logic [HndW-1:0] ses_handle = '0;
  logic [AttW-1:0] ses_tries  = '0;
  logic [PerW-1:0] cfg_period = PeriodReset;
  logic [LimW-1:0] cfg_limit  = LimitReset;

  cmd_word_t step_out[$];
  cmd_word_t due_cmds[$];
  cmd_word_t seen_w, due_w;
  int        mismatches = 0;
  int        stuck = 0;
  int        fail_bias = 40;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  bit        hold_req = 1'b0;

  playback_session_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic cmd_word_t mkw(input logic [CmdW-1:0] c, input logic [ValW-1:0] v,
                                    input logic [StW-1:0] st, input logic [VolW-1:0] vol,
                                    input logic [HndW-1:0] hnd, input logic last);
    cmd_word_t w;
    w.cmd = c;
    w.value = v;
    w.st = st;
    w.vol = vol;
    w.hnd = hnd;
    w.last = last;
    return w;
  endfunction

  function automatic void emit(input logic [CmdW-1:0] c, input logic [ValW-1:0] v);
    step_out.push_back(mkw(c, v, '0, '0, '0, 1'b0));
  endfunction

  // backoff: period doubles with each attempt until the limit is used up
  function automatic ses_state_t try_restart();
    if (ses_tries >= cfg_limit) return S_ERROR;
    emit(CMD_ARM, 32'(cfg_period) << ses_tries);
    ses_tries = ses_tries + 1'b1;
    return S_RESTART;
  endfunction

  function automatic void session_step(input logic [OpW-1:0] op, input logic [ArgW-1:0] arg);
    ses_state_t nxt;
    cmd_word_t  w;
    step_out.delete();
    nxt = ses_state;
    if (op == OP_STATUS) begin
      step_out.push_back(mkw(CMD_STATUS, '0, ses_state, ses_volume, ses_handle, 1'b1));
      return;
    end
    case (ses_state)
      S_LINK: if (op == OP_LINK_UP) nxt = S_IP;
      S_IP: begin
        if (op == OP_GOT_IP) nxt = S_READY;
        else if (op == OP_LINK_DOWN) nxt = S_LINK;
      end
      S_READY: begin
        if (op == OP_START) begin
          ses_handle = arg;
          emit(CMD_STREAM_START, ses_handle);
          nxt = S_STREAM;
        end else if (op == OP_VOLUME) begin
          ses_volume = arg[7:0];
          emit(CMD_VOLUME, 32'(ses_volume));
        end else if (op == OP_LINK_DOWN) begin
          nxt = S_LINK;
        end
      end
      S_STREAM: begin
        if (op == OP_STREAM_OK) begin
          emit(CMD_DEC_START, '0);
          nxt = S_DECODER;
        end else if (op == OP_STREAM_NG) begin
          nxt = try_restart();
        end
      end
      S_DECODER: begin
        if (op == OP_DEC_OK) begin
          emit(CMD_PLAY_START, 32'(arg[15:0]));
          nxt = S_PLAYER;
        end else if (op == OP_DEC_NG) begin
          emit(CMD_STREAM_STOP, '0);
          nxt = try_restart();
        end
      end
      S_PLAYER: begin
        if (op == OP_PLAY_OK) begin
          ses_tries = '0;
          nxt = S_RUNNING;
        end
      end
      S_RUNNING: begin
        if (op == OP_LINK_DOWN || op == OP_STOP) begin
          emit(CMD_PLAY_STOP, '0);
          emit(CMD_DEC_STOP, '0);
          emit(CMD_STREAM_STOP, '0);
          nxt = (op == OP_LINK_DOWN) ? S_LINK : S_READY;
        end else if (op == OP_STREAM_NG) begin
          emit(CMD_PLAY_STOP, '0);
          emit(CMD_DEC_STOP, '0);
          nxt = try_restart();
        end else if (op == OP_VOLUME) begin
          ses_volume = arg[7:0];
          emit(CMD_VOLUME, 32'(ses_volume));
        end
      end
      S_RESTART: begin
        if (op == OP_RESTART) begin
          emit(CMD_STREAM_START, ses_handle);
          nxt = S_STREAM;
        end else if (op == OP_LINK_DOWN) begin
          emit(CMD_TIMER_STOP, '0);
          nxt = S_LINK;
        end else if (op == OP_STOP) begin
          emit(CMD_TIMER_STOP, '0);
          nxt = S_READY;
        end
      end
      S_ERROR: begin
        if (op == OP_LINK_DOWN) begin
          nxt = S_LINK;
        end else if (op == OP_STOP) begin
          ses_tries = '0;
          nxt = S_READY;
        end else if (op == OP_START) begin
          ses_tries = '0;
          ses_handle = arg;
          emit(CMD_STREAM_START, ses_handle);
          nxt = S_STREAM;
        end else if (op == OP_VOLUME) begin
          ses_volume = arg[7:0];
          emit(CMD_VOLUME, 32'(ses_volume));
        end
      end
      default: ;
    endcase
    ses_state = nxt;
    if (step_out.size() != 0) begin
      w = step_out.pop_back();
      w.last = 1'b1;
      step_out.push_back(w);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly events that move the session along, some noise
  function automatic logic [OpW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 4'($urandom_range(0, 15));
    if (r < 14) return OP_STATUS;
    r = $urandom_range(0, 99);
    case (ses_state)
      S_LINK:    return OP_LINK_UP;
      S_IP:      return (r < 90) ? OP_GOT_IP : OP_LINK_DOWN;
      S_READY:   return (r < 55) ? OP_START : (r < 90) ? OP_VOLUME : OP_LINK_DOWN;
      S_STREAM:  return (r < fail_bias) ? OP_STREAM_NG : OP_STREAM_OK;
      S_DECODER: return (r < fail_bias) ? OP_DEC_NG : OP_DEC_OK;
      S_PLAYER:  return OP_PLAY_OK;
      S_RUNNING: begin
        if (r < fail_bias) return OP_STREAM_NG;
        r = $urandom_range(0, 9);
        return (r < 5) ? OP_VOLUME : (r < 8) ? OP_STOP : OP_LINK_DOWN;
      end
      S_RESTART: return (r < 75) ? OP_RESTART : (r < 92) ? OP_STOP : OP_LINK_DOWN;
      S_ERROR:   return (r < 50) ? OP_START : (r < 70) ? OP_STOP :
                        (r < 90) ? OP_VOLUME : OP_LINK_DOWN;
      default:   return OP_STATUS;
    endcase
  endfunction

  function automatic string show(input cmd_word_t w);
    return $sformatf("cmd %0d value %h state %0d volume %0d stream %h last %0b",
                     w.cmd, w.value, w.st, w.vol, w.hnd, w.last);
  endfunction

  function automatic stim_row_t ev(input logic [OpW-1:0] op, input logic [ArgW-1:0] arg);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = 1'b0;
    r.reg_val = '0;
    r.op = op;
    r.arg = arg;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t evk(input logic [OpW-1:0] op, input logic [ArgW-1:0] arg,
                                    input cmd_word_t w);
    stim_row_t r;
    r = ev(op, arg);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic stim_row_t cf(input logic idx, input logic [PerW-1:0] val);
    stim_row_t r;
    r = ev(OP_STATUS, '0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic send_event(input logic [OpW-1:0] op, input logic [ArgW-1:0] arg,
                            input bit typed, input cmd_word_t want, output bit handled);
    int         g;
    ses_state_t was;
    g = tx_idle ? pick_gap() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, arg, op};
    do @(posedge clk); while (!s_tready);
    was = ses_state;
    session_step(op, arg);
    handled = (step_out.size() != 0) || (ses_state != was);
    if (typed) due_cmds.push_back(want);
    else foreach (step_out[i]) due_cmds.push_back(step_out[i]);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_cmds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PerW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PERIOD) cfg_period = val;
    else cfg_limit = val[LimW-1:0];
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [PerW-1:0] period, input logic [LimW-1:0] limit,
                           input int bias, input bit tx_on, input bit rx_on, input bit squeeze);
    int             counted;
    bit             handled;
    logic [OpW-1:0] op;
    settle();
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_LIMIT, {12'($urandom), limit});
    fail_bias = bias;
    tx_idle = tx_on;
    rx_idle = rx_on;
    if (squeeze) hold_req = 1'b1;
    counted = 0;
    while (counted < PhaseItems) begin
      op = pick_op();
      send_event(op, 32'($urandom), 1'b0, '0, handled);
      if (handled) counted++;
      if (squeeze && handled && counted == PhaseItems / 2) settle();
    end
  endtask

  // output side: random back-pressure, plus one long hold when asked
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        g = rx_idle ? pick_gap() : 0;
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_w = {m_tdata[3:0], m_tdata[35:4], m_tdata[39:36], m_tdata[47:40],
                m_tdata[79:48], m_tlast};
      if (due_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", show(seen_w));
      end else begin
        due_w = due_cmds.pop_front();
        if (seen_w !== due_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s, got %s", show(due_w), show(seen_w));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= WatchLimit) begin
        $display("playback_session_controller_tb failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    bit        handled;
    rows.push_back(evk(OP_STATUS, '0, mkw(CMD_STATUS, '0, S_LINK, VolumeReset, '0, 1'b1)));
    rows.push_back(ev(4'd15, 32'hffff_ffff));
    rows.push_back(ev(OP_LINK_UP, '0));
    rows.push_back(ev(OP_LINK_DOWN, '0));
    rows.push_back(ev(OP_LINK_UP, 32'hffff_ffff));
    rows.push_back(ev(OP_GOT_IP, '0));
    rows.push_back(evk(OP_VOLUME, 32'hffff_ffff, mkw(CMD_VOLUME, 32'd255, '0, '0, '0, 1'b1)));
    rows.push_back(evk(OP_VOLUME, 32'hffff_ff00, mkw(CMD_VOLUME, '0, '0, '0, '0, 1'b1)));
    rows.push_back(evk(OP_START, 32'hffff_ffff,
                       mkw(CMD_STREAM_START, 32'hffff_ffff, '0, '0, '0, 1'b1)));
    rows.push_back(evk(OP_STREAM_NG, '0, mkw(CMD_ARM, 32'd1000, '0, '0, '0, 1'b1)));
    rows.push_back(evk(OP_RESTART, '0,
                       mkw(CMD_STREAM_START, 32'hffff_ffff, '0, '0, '0, 1'b1)));
    rows.push_back(ev(OP_STREAM_OK, '0));
    rows.push_back(ev(OP_DEC_NG, '0));
    rows.push_back(ev(OP_RESTART, '0));
    rows.push_back(ev(OP_STREAM_OK, '0));
    rows.push_back(evk(OP_DEC_OK, 32'hffff_ffff,
                       mkw(CMD_PLAY_START, 32'h0000_ffff, '0, '0, '0, 1'b1)));
    rows.push_back(ev(OP_PLAY_OK, '0));
    rows.push_back(ev(OP_VOLUME, 32'h0000_005a));
    // no retries allowed: failure while running goes straight to error
    rows.push_back(cf(CFG_LIMIT, 16'h0000));
    rows.push_back(cf(CFG_PERIOD, 16'h0000));
    rows.push_back(ev(OP_STREAM_NG, '0));
    rows.push_back(evk(OP_STATUS, '0,
                       mkw(CMD_STATUS, '0, S_ERROR, 8'h5a, 32'hffff_ffff, 1'b1)));
    // one retry with a zero base period, then the limit is hit
    rows.push_back(cf(CFG_LIMIT, 16'h0001));
    rows.push_back(ev(OP_START, 32'h8000_0001));
    rows.push_back(evk(OP_STREAM_NG, '0, mkw(CMD_ARM, '0, '0, '0, '0, 1'b1)));
    rows.push_back(ev(OP_RESTART, '0));
    rows.push_back(ev(OP_STREAM_NG, '0));
    rows.push_back(ev(OP_STOP, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_event(rows[i].op, rows[i].arg, rows[i].typed, rows[i].want, handled);
      end
    end

    run_phase(16'd1, 4'd15, 95, 1'b1, 1'b1, 1'b0);
    run_phase(16'hffff, 4'd15, 95, 1'b0, 1'b0, 1'b0);
    run_phase(16'd0, 4'd0, 40, 1'b0, 1'b1, 1'b1);
    run_phase(16'($urandom), 4'($urandom), 50, 1'b1, 1'b1, 1'b0);
    run_phase(16'd1000, 4'd4, 30, 1'b1, 1'b1, 1'b0);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && due_cmds.size() == 0) begin
      $display("playback_session_controller_tb passed");
    end else begin
      $display("playback_session_controller_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/psc_pkg.sv
sv/psc_front.sv
sv/psc_queue.sv
sv/psc_back.sv
sv/playback_session_controller.sv
bench/playback_session_controller_tb.sv
